>>> design/rpf_pkg.sv
// Shared types, constants and the CRC-8 byte update for the packet framer.
`default_nettype none
package rpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 60;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned NODE_W      = 4;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  localparam int unsigned CMDQ_AW    = 2;
  localparam int unsigned CMDQ_DEPTH = 1 << CMDQ_AW;
  localparam int unsigned OUTQ_AW    = 2;
  localparam int unsigned OUTQ_DEPTH = 1 << OUTQ_AW;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd1;
  localparam logic [1:0] ERR_NO_PACKET  = 2'd2;
  localparam logic [1:0] ERR_START_OPEN = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [1:0] CFG_SOURCE  = 2'd0;
  localparam logic [1:0] CFG_DEST    = 2'd1;
  localparam logic [1:0] CFG_VERSION = 2'd2;

  typedef struct packed {
    logic             op;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] dest_node;
    logic [NODE_W-1:0] format_version;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_ERR   = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [1:0]       err;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             last;
  } cmd_t;

  // MSB-first CRC-8 update, one byte.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/rpf_cmdq.sv
// Short command queue between the classifying front and the emitting back.
`default_nettype none
module rpf_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire rpf_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          rd_en,
  output rpf_pkg::cmd_t      head,
  output logic               empty
);
  import rpf_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;

  assign full  = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/rpf_front.sv
// Front part: configuration registers, packet tracking and word classification.
`default_nettype none
module rpf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rpf_pkg::in_item_t in_item,
  output logic                   full,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [3:0]        cfg_data,
  output rpf_pkg::cfg_t          cfg,
  output logic                   cmd_push,
  output rpf_pkg::cmd_t          cmd,
  input  wire logic              cmd_full
);
  import rpf_pkg::*;

  logic             packet_open;
  logic             packet_open_next;
  logic [LEN_W-1:0] bytes_remaining;
  logic [LEN_W-1:0] bytes_remaining_next;

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_node    <= NODE_W'(1);
      cfg.dest_node      <= NODE_W'(15);
      cfg.format_version <= NODE_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOURCE:  cfg.source_node    <= cfg_data;
        CFG_DEST:    cfg.dest_node      <= cfg_data;
        CFG_VERSION: cfg.format_version <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_comb begin
    cmd.kind             = CMD_ERR;
    cmd.err              = ERR_OK;
    cmd.len              = in_item.payload_len;
    cmd.data             = in_item.data_byte;
    cmd.last             = (bytes_remaining == LEN_W'(1));
    packet_open_next     = packet_open;
    bytes_remaining_next = bytes_remaining;
    if (in_item.op == OP_START) begin
      if (packet_open) begin
        cmd.err = ERR_START_OPEN;
      end else if (in_item.payload_len > LEN_W'(MAX_PAYLOAD)) begin
        cmd.err = ERR_TOO_LONG;
      end else begin
        cmd.kind             = CMD_START;
        packet_open_next     = (in_item.payload_len != '0);
        bytes_remaining_next = in_item.payload_len;
      end
    end else begin
      if (!packet_open) begin
        cmd.err = ERR_NO_PACKET;
      end else begin
        cmd.kind             = CMD_DATA;
        bytes_remaining_next = bytes_remaining - 1'b1;
        packet_open_next     = (bytes_remaining != LEN_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open     <= 1'b0;
      bytes_remaining <= '0;
    end else if (cmd_push) begin
      packet_open     <= packet_open_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule
`default_nettype wire

>>> design/rpf_back.sv
// Back part: expands commands into framed words, runs the CRC, queues results.
`default_nettype none
module rpf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rpf_pkg::cfg_t cfg,
  input  wire rpf_pkg::cmd_t head,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output rpf_pkg::out_item_t out_item,
  output logic               empty,
  input  wire logic          pop
);
  import rpf_pkg::*;

  logic [1:0]          phase;
  logic [7:0]          crc;
  logic [7:0]          crc_next;
  out_item_t           word;
  logic                is_data;
  logic                done;
  logic                emit;
  logic                oq_pop;

  out_item_t           oq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]  oq_wr;
  logic [OUTQ_AW-1:0]  oq_rd;
  logic [OUTQ_AW:0]    oq_count;

  assign empty    = (oq_count == '0);
  assign oq_pop   = pop && !empty;
  assign out_item = oq[oq_rd];
  assign emit     = !cmd_empty && (oq_count != (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign cmd_pop  = emit && done;

  always_comb begin
    word.out_byte   = 8'h00;
    word.frame_end  = 1'b0;
    word.error_code = ERR_OK;
    is_data         = 1'b0;
    done            = 1'b1;
    unique case (head.kind)
      CMD_START: begin
        case (phase)
          2'd0: begin
            word.out_byte = {cfg.format_version, 4'h0};
            is_data       = 1'b1;
            done          = 1'b0;
          end
          2'd1: begin
            word.out_byte = {head.len, 2'b00};
            is_data       = 1'b1;
            done          = 1'b0;
          end
          2'd2: begin
            word.out_byte = {cfg.source_node, cfg.dest_node};
            is_data       = 1'b1;
            done          = (head.len != '0);
          end
          default: begin
            word.out_byte  = crc;
            word.frame_end = 1'b1;
          end
        endcase
      end
      CMD_DATA: begin
        if (phase == 2'd0) begin
          word.out_byte = head.data;
          is_data       = 1'b1;
          done          = !head.last;
        end else begin
          word.out_byte  = crc;
          word.frame_end = 1'b1;
        end
      end
      default: begin
        word.error_code = head.err;
      end
    endcase
  end

  // Restart the CRC at each header, clear it after the closing CRC word.
  always_comb begin
    crc_next = crc;
    if (is_data) begin
      crc_next = crc8_update((head.kind == CMD_START && phase == 2'd0) ? 8'h00 : crc,
                             word.out_byte);
    end else if (word.frame_end) begin
      crc_next = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      crc   <= '0;
    end else if (emit) begin
      phase <= done ? 2'd0 : phase + 1'b1;
      crc   <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq[oq_wr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (emit) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      case ({emit, oq_pop})
        2'b10:   oq_count <= oq_count + 1'b1;
        2'b01:   oq_count <= oq_count - 1'b1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    (!cmd_empty && head.kind == CMD_DATA) |-> (phase == 2'd0 || phase == 2'd1))
    else $error("data command past its CRC word");

  a_crc_cleared: assert property (@(posedge clk) disable iff (rst)
    (emit && word.frame_end) |=> (crc == 8'h00))
    else $error("CRC not cleared after frame end");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (emit && word.error_code != ERR_OK) |-> (cmd_pop && word.out_byte == 8'h00))
    else $error("error word not a single zero word");

endmodule
`default_nettype wire

>>> design/radio_packet_framer_crc8_core.sv
// Top level of the radio packet framer with CRC-8 trailer.
// A result word passes the command queue and then the output queue before it can be
// popped. Throughput, while neither queue is full: one input word per cycle while each
// yields one result word; the back part emits one result word per cycle.
// Reset (synchronous, rst high): both queues empty, no packet open, CRC zero,
// source_node 1, dest_node 15, format_version 1.
`default_nettype none
module radio_packet_framer_crc8_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rpf_pkg::in_item_t in_item,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output rpf_pkg::out_item_t     out_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [3:0]        cfg_data
);
  import rpf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  cmd_t head;
  logic cmd_push;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;

  assign cfg_ready = 1'b1;

  rpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .cmd_full  (cmd_full)
  );

  rpf_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .head   (head),
    .empty  (cmd_empty)
  );

  rpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the radio packet framer with CRC-8 trailer.
`timescale 1ns / 1ps
module testbench;
  import rpf_pkg::*;

  localparam logic [1:0] CFG_NONE = 2'd3;   // index past the register list
  localparam int SETTLE_CYCLES = 6;
  localparam int PRINT_CAP = 30;

  typedef enum logic [1:0] {ACT_WORD, ACT_REG, ACT_SETTLE} act_kind_t;

  typedef struct {
    act_kind_t  kind;
    in_item_t   word;
    logic [1:0] idx;
    logic [3:0] val;
    bit         quiet;
  } act_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  in_item_t   in_item = '0;
  logic       full;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SOURCE;
  logic [3:0] cfg_data = 4'h0;

  radio_packet_framer_crc8_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  act_t      plan[$];
  out_item_t frame_words[$];
  int        words_planned = 0;
  bit        quiet_fill = 1'b0;
  bit        quiet_now = 1'b0;
  bit        all_done = 1'b1;
  int        mismatches = 0;
  int        gap_left = 0;
  int        settle_cnt = 0;
  int        stall_left = 0;

  // predictor copy of the framer state
  cfg_t       node_cfg;
  logic [7:0] crc_acc;
  logic [5:0] left_cnt;
  bit         pkt_open;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // MSB-first CRC-8, polynomial 0xD5, one bit at a time
  function automatic logic [7:0] crc8_dvbs2_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0};
      if (fb) c = c ^ 8'hD5;
    end
    return c;
  endfunction

  function automatic void expect_word(input logic [7:0] b, input logic e, input logic [1:0] err);
    out_item_t x;
    x.out_byte = b;
    x.frame_end = e;
    x.error_code = err;
    frame_words.push_back(x);
  endfunction

  function automatic void emit_framed(input logic [7:0] b);
    expect_word(b, 1'b0, ERR_OK);
    crc_acc = crc8_dvbs2_step(crc_acc, b);
  endfunction

  function automatic void close_frame();
    expect_word(crc_acc, 1'b1, ERR_OK);
    crc_acc = 8'h00;
    pkt_open = 1'b0;
  endfunction

  function automatic void frame_predict(input in_item_t w);
    logic [7:0] hdr [3];
    if (w.op == OP_START) begin
      if (pkt_open) begin
        expect_word(8'h00, 1'b0, ERR_START_OPEN);
      end else if (w.payload_len > MAX_PAYLOAD) begin
        expect_word(8'h00, 1'b0, ERR_TOO_LONG);
      end else begin
        crc_acc = 8'h00;
        hdr[0] = {node_cfg.format_version, 4'h0};
        hdr[1] = {w.payload_len, 2'b00};
        hdr[2] = {node_cfg.source_node, node_cfg.dest_node};
        foreach (hdr[i]) emit_framed(hdr[i]);
        left_cnt = w.payload_len;
        pkt_open = 1'b1;
        if (w.payload_len == 0) close_frame();
      end
    end else if (!pkt_open) begin
      expect_word(8'h00, 1'b0, ERR_NO_PACKET);
    end else begin
      emit_framed(w.data_byte);
      left_cnt = left_cnt - 6'd1;
      if (left_cnt == 0) close_frame();
    end
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [3:0] v);
    case (idx)
      CFG_SOURCE:  node_cfg.source_node = v;
      CFG_DEST:    node_cfg.dest_node = v;
      CFG_VERSION: node_cfg.format_version = v;
      default: ;
    endcase
  endfunction

  task automatic plan_word(input logic op, input logic [5:0] len, input logic [7:0] b);
    act_t a;
    a.kind = ACT_WORD;
    a.word.op = op;
    a.word.payload_len = len;
    a.word.data_byte = b;
    a.idx = CFG_SOURCE;
    a.val = 4'h0;
    a.quiet = quiet_fill;
    plan.push_back(a);
    words_planned++;
  endtask

  task automatic plan_start(input logic [5:0] len);
    plan_word(OP_START, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic plan_byte(input logic [7:0] b);
    plan_word(OP_DATA, 6'($urandom_range(0, 63)), b);
  endtask

  task automatic plan_packet(input int len);
    plan_start(6'(len));
    repeat (len) plan_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic plan_reg(input logic [1:0] idx, input logic [3:0] v);
    act_t a;
    a.kind = ACT_REG;
    a.word = '0;
    a.idx = idx;
    a.val = v;
    a.quiet = quiet_fill;
    plan.push_back(a);
  endtask

  task automatic plan_settle();
    act_t a;
    a.kind = ACT_SETTLE;
    a.word = '0;
    a.idx = CFG_SOURCE;
    a.val = 4'h0;
    a.quiet = quiet_fill;
    plan.push_back(a);
  endtask

  // Input side: issue words and register writes from the plan.
  always @(posedge clk) begin : drive_words
    logic push_nx;
    logic cfgv_nx;
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      settle_cnt = 0;
    end else begin
      push_nx = push && full;
      cfgv_nx = cfg_valid && !cfg_ready;
      if (push && !full) settle_cnt = 0;
      if (!push_nx && !cfgv_nx && plan.size() != 0) begin
        quiet_now <= plan[0].quiet;
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          case (plan[0].kind)
            ACT_WORD: begin
              if (!plan[0].quiet && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 16) - 1;
              end else begin
                in_item <= plan[0].word;
                push_nx = 1'b1;
                void'(plan.pop_front());
              end
            end
            ACT_REG: begin
              cfg_index <= plan[0].idx;
              cfg_data <= plan[0].val;
              cfgv_nx = 1'b1;
              void'(plan.pop_front());
            end
            default: begin
              // wait until every expected word is out and no push is pending, then let the design settle
              if (!all_done || push) begin
                settle_cnt = 0;
              end else if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(plan.pop_front());
              end else begin
                settle_cnt++;
              end
            end
          endcase
        end
      end
      push <= push_nx;
      cfg_valid <= cfgv_nx;
    end
  end

  // Output side: predict on accepted inputs, check popped words, stall pop.
  always @(posedge clk) begin : watch_words
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
      all_done <= 1'b1;
      node_cfg.source_node = 4'd1;
      node_cfg.dest_node = 4'd15;
      node_cfg.format_version = 4'd1;
      crc_acc = 8'h00;
      left_cnt = 6'd0;
      pkt_open = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (push && !full) frame_predict(in_item);
      if (pop && !empty) begin
        if (frame_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_item));
        end else begin
          want = frame_words.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h",
                                      out_item.out_byte, want.out_byte));
          if (out_item.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, want %b",
                                      out_item.frame_end, want.frame_end));
          if (out_item.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d",
                                      out_item.error_code, want.error_code));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!quiet_now && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      all_done <= (frame_words.size() == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int target;
    int pick;
    int len;
    int cut;
    // directed: default registers, empty payload, errors, start while open
    plan_start(6'd0);
    plan_start(6'd1);
    plan_byte(8'hFF);
    plan_byte(8'h00);
    plan_start(6'd61);
    plan_start(6'd63);
    plan_start(6'd2);
    plan_start(6'd5);
    plan_byte(8'hA5);
    plan_byte(8'h5A);
    plan_settle();
    plan_reg(CFG_SOURCE, 4'h0);
    plan_reg(CFG_DEST, 4'h0);
    plan_reg(CFG_VERSION, 4'h0);
    plan_reg(CFG_NONE, 4'hF);
    plan_start(6'd3);
    plan_byte(8'h00);
    plan_byte(8'hFF);
    plan_byte(8'h80);
    plan_settle();
    plan_reg(CFG_SOURCE, 4'hF);
    plan_reg(CFG_DEST, 4'hF);
    plan_reg(CFG_VERSION, 4'hF);
    plan_start(6'd0);
    plan_start(6'd1);
    plan_byte(8'h7F);

    // random phases, new register values between them; last phase runs flat out
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) quiet_fill = 1'b1;
      plan_settle();
      for (int r = 0; r < 4; r++)
        if ($urandom_range(0, 3) != 0) plan_reg(2'(r), 4'($urandom_range(0, 15)));
      if (ph == 1) plan_packet(MAX_PAYLOAD);
      target = words_planned + ((ph == 4) ? 30 : 60);
      while (words_planned < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
          len = (pick < 11) ? $urandom_range(0, 8) : $urandom_range(0, MAX_PAYLOAD);
          plan_packet(len);
        end else if (pick == 15) begin
          plan_start(6'($urandom_range(MAX_PAYLOAD + 1, 63)));
        end else if (pick == 16) begin
          plan_byte(8'($urandom_range(0, 255)));
        end else if (pick == 17) begin
          // broken packet: a start lands mid-payload, then the payload finishes
          len = $urandom_range(2, 10);
          cut = $urandom_range(0, len - 1);
          plan_start(6'(len));
          repeat (cut) plan_byte(8'($urandom_range(0, 255)));
          plan_start(6'($urandom_range(0, 63)));
          repeat (len - cut) plan_byte(8'($urandom_range(0, 255)));
        end else begin
          plan_word(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                    8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // sample between edges so the driver and monitor updates have settled
    @(negedge clk);
    while (plan.size() != 0 || push || !all_done) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (frame_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", frame_words.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
